// ----- hdl/primer_offset_finder_macros.svh -----
// ---------------------------------------------------------------------------
// primer offset finder assertion macros
// concurrent check forms used by the primer_offset_finder module
// ---------------------------------------------------------------------------
`ifndef PRIMER_OFFSET_FINDER_MACROS_SVH
`define PRIMER_OFFSET_FINDER_MACROS_SVH

// condition holds at every clock edge out of reset
`define POF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pof invariant violated");

// consequent holds in the same cycle as the antecedent
`define POF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pof implication violated");

`endif

// ----- hdl/pof_pkg.sv -----
// ---------------------------------------------------------------------------
// pof_pkg
// types, constants and exp factor table for the primer offset finder
// ---------------------------------------------------------------------------
`default_nettype none

package pof_pkg;

    localparam int LOGP_BITS          = 24;
    localparam int MASK_BITS          = 4;
    localparam int OFFSET_BITS        = 10;
    localparam int SUM_BITS           = 32;
    localparam int EXP_BITS           = 17;
    localparam int QUOT_BITS          = 32;
    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 64;
    localparam int PENALTY_BITS       = 16;
    localparam int PLEN_BITS          = 5;
    localparam int PRIMER_BITS        = 64;
    localparam int SEQ_MAX_DEFAULT    = 512;
    localparam int PRIMER_MAX_DEFAULT = 16;

    localparam logic [EXP_BITS-1:0]  ONE_Q16   = 17'd65536;
    localparam logic [16:0]          LOG2E_Q16 = 17'd94548;
    localparam logic [MASK_BITS-1:0] MASK_N    = 4'hF;

    localparam logic signed [LOGP_BITS-1:0] THRESHOLD_RESET = -24'sd45875;
    localparam logic [PLEN_BITS-1:0]        PLEN_RESET      = 5'd1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_PENALTY   = 3'd1,
        CFG_REVERSE   = 3'd2,
        CFG_PRIMER    = 3'd3,
        CFG_PLEN      = 3'd4
    } pof_cfg_t;

    typedef struct packed {
        logic [MASK_BITS-1:0]        base_mask;
        logic signed [LOGP_BITS-1:0] match_logp;
        logic signed [LOGP_BITS-1:0] mismatch_logp;
        logic                        last_base;
    } pof_base_word_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] best_offset;
        logic                   read_overflow;
    } pof_result_word_t;

    typedef struct packed {
        logic [MASK_BITS-1:0]        mask;
        logic signed [LOGP_BITS-1:0] p;
        logic signed [LOGP_BITS-1:0] np;
    } pof_entry_t;

    localparam int ENTRY_BITS = $bits(pof_entry_t);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_INIT_EXP,
        ST_READ,
        ST_DIV,
        ST_EXP,
        ST_SCORE,
        ST_FINISH
    } pof_state_t;

    typedef enum logic [1:0] {
        EXP_IDLE,
        EXP_MUL,
        EXP_ITER,
        EXP_ROUND
    } pof_exp_state_t;

    // 2^-(2^-k) in q30, by k-fold integer square root of one half
    function automatic logic [30:0] halving_root(input int k);
        logic [63:0] cur;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        cur = 64'd1 << 29;
        for (int j = 1; j <= 16; j++) begin
            if (j <= k) begin
                v = cur << 30;
                r = '0;
                b = 64'd1 << 62;
                for (int t = 0; t < 32; t++) begin
                    if (v >= r + b) begin
                        v = v - (r + b);
                        r = (r >> 1) + b;
                    end else begin
                        r = r >> 1;
                    end
                    b = b >> 2;
                end
                cur = r;
            end
        end
        return cur[30:0];
    endfunction

    localparam logic [30:0] ROOT_TABLE [16] = '{
        halving_root(1),  halving_root(2),  halving_root(3),  halving_root(4),
        halving_root(5),  halving_root(6),  halving_root(7),  halving_root(8),
        halving_root(9),  halving_root(10), halving_root(11), halving_root(12),
        halving_root(13), halving_root(14), halving_root(15), halving_root(16)
    };

endpackage

`default_nettype wire

// ----- hdl/pof_ram.sv -----
// ---------------------------------------------------------------------------
// pof_ram
// simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module pof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/pof_div.sv -----
// ---------------------------------------------------------------------------
// pof_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module pof_div #(
    parameter int DIVISOR_BITS = 10
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [pof_pkg::QUOT_BITS-1:0]    dividend,
    input  wire logic [DIVISOR_BITS-1:0]          divisor,
    output logic                                  done,
    output logic      [pof_pkg::QUOT_BITS-1:0]    quotient
);

    import pof_pkg::*;

    localparam int CNT_W = $clog2(QUOT_BITS);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0] dsr_reg, dsr_next;
    logic [QUOT_BITS-1:0]    quot_reg, quot_next;
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[QUOT_BITS-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_BITS - 1);
            rem_next  = '0;
            dsr_next  = divisor;
            quot_next = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = diff[DIVISOR_BITS-1:0];
                quot_next = {quot_reg[QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DIVISOR_BITS-1:0];
                quot_next = {quot_reg[QUOT_BITS-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ----- hdl/pof_exp.sv -----
// ---------------------------------------------------------------------------
// pof_exp
// exp(-x) in q1.16 as 2^-(x log2 e), one fraction factor per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module pof_exp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [pof_pkg::QUOT_BITS-1:0]  x,
    output logic                                done,
    output logic      [pof_pkg::EXP_BITS-1:0]   result
);

    import pof_pkg::*;

    localparam int Y_BITS = QUOT_BITS + 17;

    pof_exp_state_t        phase_reg, phase_next;
    logic                  done_reg, done_next;
    logic [QUOT_BITS-1:0]  x_reg, x_next;
    logic [Y_BITS-1:0]     y_reg, y_next;
    logic [30:0]           acc_reg, acc_next;
    logic [3:0]            k_reg, k_next;
    logic [EXP_BITS-1:0]   result_reg, result_next;
    logic [61:0]           prod;
    logic [61:0]           prod_rnd;
    logic [15:0]           frac;
    logic [Y_BITS-33:0]    whole;
    logic [32:0]           acc_rnd;

    always_comb
    begin
        phase_next  = phase_reg;
        done_next   = 1'b0;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        k_next      = k_reg;
        result_next = result_reg;
        frac        = y_reg[31:16];
        whole       = y_reg[Y_BITS-1:32];
        prod        = 62'(acc_reg) * 62'(ROOT_TABLE[k_reg]);
        prod_rnd    = (prod + (62'd1 << 29)) >> 30;
        acc_rnd     = 33'(acc_reg) + (33'd1 << (13 + 33'(whole[4:0])));
        unique case (phase_reg)
            EXP_IDLE:
            begin
                if (start)
                begin
                    x_next     = x;
                    phase_next = EXP_MUL;
                end
            end
            EXP_MUL:
            begin
                y_next     = Y_BITS'(x_reg) * Y_BITS'(LOG2E_Q16);
                acc_next   = 31'd1 << 30;
                k_next     = '0;
                phase_next = EXP_ITER;
            end
            EXP_ITER:
            begin
                if (frac[4'd15 - k_reg])
                begin
                    acc_next = prod_rnd[30:0];
                end
                if (k_reg == 4'd15)
                begin
                    phase_next = EXP_ROUND;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            EXP_ROUND:
            begin
                // integer part of 17 or more underflows to zero
                if (whole >= (Y_BITS-32)'(17))
                begin
                    result_next = '0;
                end
                else
                begin
                    result_next = EXP_BITS'(acc_rnd >> (14 + 33'(whole[4:0])));
                end
                done_next  = 1'b1;
                phase_next = EXP_IDLE;
            end
            default:
            begin
                phase_next = EXP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= EXP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- hdl/primer_offset_finder.sv -----
// ---------------------------------------------------------------------------
// primer_offset_finder
// loads a read into a base store and scans it for the best primer placement
// ---------------------------------------------------------------------------
// each accepted base word is written to the base store as it is taken, so a
// read loads at one word per cycle. the word marked last starts the scan and
// no base word is taken until the scan ends. the scan first sets up the exp
// of a negative start threshold. per read base it scores if the retiring
// offset sum is empty or non-negative, else it runs the divider (one
// quotient bit per cycle, then a done strobe) on the negated sum over step
// plus one, then the exp unit (a multiply, one table factor per cycle on
// its multiplier, a rounding step and a done strobe). the per-offset sums
// live in a ring of registers that all update in the same cycle. the
// result word waits in an output register while the next read loads.
// ---------------------------------------------------------------------------
`default_nettype none
`include "primer_offset_finder_macros.svh"

module primer_offset_finder #(
    parameter int SEQ_MAX    = pof_pkg::SEQ_MAX_DEFAULT,
    parameter int PRIMER_MAX = pof_pkg::PRIMER_MAX_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // base word channel
    input  wire logic                                base_valid,
    output logic                                     base_stall,
    input  wire pof_pkg::pof_base_word_t             base_word,
    // result word channel
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output pof_pkg::pof_result_word_t                result_word,
    // configuration writes
    input  wire logic                                cfg_write,
    input  wire logic [pof_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [pof_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import pof_pkg::*;

    localparam int AW    = $clog2(SEQ_MAX);
    localparam int CW    = $clog2(SEQ_MAX + 1);
    localparam int PW    = $clog2(PRIMER_MAX);
    localparam int LW    = $clog2(PRIMER_MAX + 1);
    localparam int THR_W = LOGP_BITS + LW + 1;

    // configuration registers
    logic signed [LOGP_BITS-1:0] threshold_reg;
    logic [PENALTY_BITS-1:0]     penalty_reg;
    logic                        reverse_reg;
    logic [PRIMER_BITS-1:0]      primer_reg;
    logic [PLEN_BITS-1:0]        plen_reg;

    // control and scan state
    pof_state_t                  state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic signed [SUM_BITS-1:0]  sum_reg [PRIMER_MAX];
    logic signed [SUM_BITS-1:0]  sum_next [PRIMER_MAX];
    logic [PRIMER_MAX-1:0]       valid_reg, valid_next;
    logic signed [SUM_BITS-1:0]  best_reg, best_next;
    logic [CW-1:0]               bestpos_reg, bestpos_next;
    logic [CW-1:0]               step_reg, step_next;
    logic [LW-1:0]               head_reg, head_next;
    logic [LW-1:0]               len_reg, len_next;
    logic [SUM_BITS-1:0]         pen_reg, pen_next;
    logic [EXP_BITS-1:0]         e_reg, e_next;
    logic                        out_valid_reg, out_valid_next;
    pof_result_word_t            out_word_reg, out_word_next;

    // store, divider and exp hookup
    logic                        wr_en;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    pof_entry_t                  wr_entry;
    pof_entry_t                  rd_entry;
    logic                        div_start;
    logic                        div_done;
    logic [QUOT_BITS-1:0]        div_quot;
    logic                        exp_start;
    logic                        exp_done;
    logic [QUOT_BITS-1:0]        exp_x;
    logic [EXP_BITS-1:0]         exp_result;

    // scan helpers
    logic [LW-1:0]               len_eff;
    logic signed [THR_W-1:0]     thr_prod;
    logic signed [SUM_BITS-1:0]  head_sum;
    logic signed [SUM_BITS-1:0]  score;
    logic [MASK_BITS-1:0]        pmask [PRIMER_MAX];
    logic signed [SUM_BITS-1:0]  ring_upd [PRIMER_MAX];
    logic [LW-1:0]               xs;
    logic [LW-1:0]               s_l;
    logic [MASK_BITS-1:0]        pm;
    logic                        take;
    logic signed [SUM_BITS-1:0]  term;
    logic signed [SUM_BITS-1:0]  base_sum;

    assign wr_entry.mask = base_word.base_mask;
    assign wr_entry.p    = base_word.match_logp;
    assign wr_entry.np   = base_word.mismatch_logp;

    pof_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SEQ_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    pof_div #(
        .DIVISOR_BITS (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (QUOT_BITS'(-head_sum)),
        .divisor  (step_reg + 1'b1),
        .done     (div_done),
        .quotient (div_quot)
    );

    pof_exp u_exp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (exp_start),
        .x      (exp_x),
        .done   (exp_done),
        .result (exp_result)
    );

    // primer length clamped to 1..PRIMER_MAX
    always_comb
    begin
        if (plen_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (PLEN_BITS'(plen_reg) > PLEN_BITS'(PRIMER_MAX))
        begin
            len_eff = LW'(PRIMER_MAX);
        end
        else
        begin
            len_eff = LW'(plen_reg);
        end
    end

    assign thr_prod = THR_W'(signed'({1'b0, len_eff})) * THR_W'(threshold_reg);
    assign head_sum = sum_reg[head_reg[PW-1:0]];
    assign score    = signed'(SUM_BITS'(e_reg)) - signed'(pen_reg);
    assign exp_x    = (state_reg == ST_INIT) ? QUOT_BITS'(-thr_prod) : div_quot;
    assign rd_addr  = reverse_reg ? AW'(count_reg - 1'b1 - step_reg) : step_reg[AW-1:0];

    // ring update: slot s takes primer position (head - s) mod len
    always_comb
    begin
        for (int j = 0; j < PRIMER_MAX; j++)
        begin
            pmask[j] = primer_reg[MASK_BITS*j +: MASK_BITS];
        end
        xs       = '0;
        s_l      = '0;
        pm       = '0;
        take     = 1'b0;
        term     = '0;
        base_sum = '0;
        for (int s = 0; s < PRIMER_MAX; s++)
        begin
            s_l = LW'(s);
            if (head_reg >= s_l)
            begin
                xs = head_reg - s_l;
            end
            else
            begin
                xs = head_reg + len_reg - s_l;
            end
            pm   = pmask[xs[PW-1:0]];
            // positions past the current step have not started yet; N adds nothing
            take = (s_l < len_reg) && (CW'(xs) <= step_reg) && (pm != MASK_N);
            if ((rd_entry.mask & pm) != '0)
            begin
                term = SUM_BITS'(rd_entry.p);
            end
            else
            begin
                term = SUM_BITS'(rd_entry.np);
            end
            // the retiring slot restarts from zero for a new offset
            base_sum    = (s_l == head_reg) ? '0 : sum_reg[s];
            ring_upd[s] = take ? (base_sum + term) : base_sum;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        sum_next       = sum_reg;
        valid_next     = valid_reg;
        best_next      = best_reg;
        bestpos_next   = bestpos_reg;
        step_next      = step_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        pen_next       = pen_reg;
        e_next         = e_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_word_next  = out_word_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        div_start      = 1'b0;
        exp_start      = 1'b0;
        base_stall     = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                base_stall = 1'b0;
                if (base_valid)
                begin
                    // a full store drops the base and flags the read
                    if (count_reg < CW'(SEQ_MAX))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (base_word.last_base)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                len_next     = len_eff;
                bestpos_next = '0;
                step_next    = '0;
                head_next    = '0;
                pen_next     = '0;
                if (thr_prod >= 0)
                begin
                    best_next  = SUM_BITS'(ONE_Q16);
                    state_next = (CW'(len_eff) > count_reg) ? ST_FINISH : ST_READ;
                end
                else
                begin
                    exp_start  = 1'b1;
                    state_next = ST_INIT_EXP;
                end
            end
            ST_INIT_EXP:
            begin
                if (exp_done)
                begin
                    best_next  = SUM_BITS'(exp_result);
                    state_next = (CW'(len_reg) > count_reg) ? ST_FINISH : ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                if (!valid_reg[head_reg[PW-1:0]])
                begin
                    e_next     = '0;
                    state_next = ST_SCORE;
                end
                else if (head_sum >= 0)
                begin
                    e_next     = ONE_Q16;
                    state_next = ST_SCORE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    exp_start  = 1'b1;
                    state_next = ST_EXP;
                end
            end
            ST_EXP:
            begin
                if (exp_done)
                begin
                    e_next     = exp_result;
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                // first strict maximum wins
                if (score > best_reg)
                begin
                    best_next    = score;
                    bestpos_next = step_reg + 1'b1;
                end
                sum_next                        = ring_upd;
                valid_next[head_reg[PW-1:0]]    = 1'b1;
                pen_next                        = pen_reg + SUM_BITS'(penalty_reg);
                if (step_reg + 1'b1 == count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    head_next  = (head_reg + 1'b1 == len_reg) ? '0 : head_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_word_next.best_offset   = OFFSET_BITS'(bestpos_reg);
                    out_word_next.read_overflow = ovf_reg;
                    count_next                  = '0;
                    ovf_next                    = 1'b0;
                    valid_next                  = '0;
                    state_next                  = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            penalty_reg   <= '0;
            reverse_reg   <= 1'b0;
            primer_reg    <= '0;
            plen_reg      <= PLEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[LOGP_BITS-1:0];
                CFG_PENALTY:   penalty_reg   <= cfg_data[PENALTY_BITS-1:0];
                CFG_REVERSE:   reverse_reg   <= cfg_data[0];
                CFG_PRIMER:    primer_reg    <= cfg_data[PRIMER_BITS-1:0];
                CFG_PLEN:      plen_reg      <= cfg_data[PLEN_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            valid_reg     <= '0;
            best_reg      <= '0;
            bestpos_reg   <= '0;
            step_reg      <= '0;
            head_reg      <= '0;
            len_reg       <= LW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            valid_reg     <= valid_next;
            best_reg      <= best_next;
            bestpos_reg   <= bestpos_next;
            step_reg      <= step_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        pen_reg      <= pen_next;
        e_reg        <= e_next;
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    `POF_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(SEQ_MAX))
    `POF_ASSERT_ALWAYS(a_head_in_ring, clk, rst_n, head_reg < len_reg)
    `POF_ASSERT_IMPLY(a_step_in_read, clk, rst_n, state_reg == ST_SCORE, step_reg < count_reg)
    `POF_ASSERT_IMPLY(a_div_owner, clk, rst_n, div_done, state_reg == ST_DIV)

endmodule

`default_nettype wire
